/* rtl/sdpd_pkg.sv */
// sdpd_pkg: widths, register indexes, sequencer states and arithmetic helpers
// for the second-difference peak detector.
// No dependencies; imported by every rtl module of the block.
package sdpd_pkg;

   // default tap spacing limit
   localparam int MAX_LAG_DEF = 64;

   // field widths
   localparam int SAMPLE_W = 13;
   localparam int BASE_W   = 12;
   localparam int GAIN_W   = 16;
   localparam int LAG_W    = 7;
   localparam int ADJ_W    = 10;
   localparam int WLEN_W   = 16;
   localparam int HOLD_W   = 16;
   localparam int IDX_W    = 16;
   localparam int PEAK_W   = 12;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // arithmetic widths
   localparam int MUL_W     = 20;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int Y_W       = 18;
   localparam int ACC_W     = 20;
   localparam int GAIN_FRAC = 12;

   // reset values of the registers
   localparam logic [BASE_W-1:0] BASE_RST = 12'd2047;
   localparam logic [GAIN_W-1:0] GAIN_RST = 16'd41;
   localparam logic [LAG_W-1:0]  LAG_RST  = 7'd8;
   localparam logic [ADJ_W-1:0]  ADJ_RST  = 10'd100;
   localparam logic [WLEN_W-1:0] WLEN_RST = 16'd64;
   localparam logic [HOLD_W-1:0] HOLD_RST = 16'd0;

   // peak clamp; values at or above it saturate early
   localparam logic [PEAK_W-1:0] PEAK_LIMIT = 12'd2048;
   // smallest percent product whose quotient by 100 reaches the clamp
   localparam int SAT_THRESH = 204800;
   // reciprocal of 100 for quotients of products below SAT_THRESH
   localparam int RECIP_SHIFT = 25;
   localparam int RECIP_W     = 18;
   localparam logic [MUL_W-1:0] RECIP_100 = 20'd335545;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASELINE   = 3'd0,
      CSR_GAIN       = 3'd1,
      CSR_LAG        = 3'd2,
      CSR_ADJUST     = 3'd3,
      CSR_WINDOW_LEN = 3'd4,
      CSR_HOLDOFF    = 3'd5
   } csr_idx_type;

   // sequencer states; the multiplier is loaded in RD_MID, RD_FAR, WR, ADJ and DIV
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_MID,
      ST_RD_FAR,
      ST_WR,
      ST_SUM,
      ST_ADJ,
      ST_DIV,
      ST_UPD
   } state_type;

   // raw sample minus zero line, as a signed multiplier operand
   function automatic logic signed [MUL_W-1:0] base_diff(
      input logic [SAMPLE_W-1:0] x,
      input logic [BASE_W-1:0]   b
   );
      logic [MUL_W-1:0] t;
      t = MUL_W'(x) - MUL_W'(b);
      return $signed(t);
   endfunction

   // gain product over 4096, truncated toward zero
   function automatic logic signed [Y_W-1:0] scale_trunc(
      input logic signed [PROD_W-1:0] p
   );
      logic [PROD_W-1:0] t;
      t = p[PROD_W-1] ? PROD_W'(p) + PROD_W'((1 << GAIN_FRAC) - 1) : PROD_W'(p);
      return $signed(t[Y_W+GAIN_FRAC-1:GAIN_FRAC]);
   endfunction

endpackage

/* rtl/sdpd_tap_ram.sv */
// sdpd_tap_ram: tap delay line storage, one write and one registered read
// per cycle. Depends on sdpd_pkg for the sample width.
module sdpd_tap_ram #(
   parameter int DEPTH = 2 * sdpd_pkg::MAX_LAG_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [sdpd_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [sdpd_pkg::SAMPLE_W-1:0] rd_data
);
   import sdpd_pkg::*;

   logic [SAMPLE_W-1:0] mem_ff [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sdpd_mul.sv */
// sdpd_mul: the shared signed multiplier with its product register.
// Depends on sdpd_pkg for operand and product widths.
module sdpd_mul (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [sdpd_pkg::MUL_W-1:0]  a,
   input  logic signed [sdpd_pkg::MUL_W-1:0]  b,
   output logic signed [sdpd_pkg::PROD_W-1:0] p
);
   import sdpd_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(a) * PROD_W'(b);

   // product register, held while the sequencer waits
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign p = prod_ff;

endmodule

/* rtl/second_difference_peak_detector.sv */
// Second-difference peak detector: one probe sample per req word, one result
// per completed window on rsp. Depends on sdpd_pkg, sdpd_tap_ram and sdpd_mul.
//
// The block takes a new sample only once the previous one is through: the
// single multiplier runs five products in turn (three gain products, the percent
// product and a reciprocal multiply for the divide by 100). The two
// delayed taps come from a single-read tap RAM, so the two reads and the write
// of the new sample are spread over the same sequence. req_tready is high only
// while the sequencer is idle. A finished window word sits in the rsp register;
// the block keeps working while it waits and only stalls at the end of the next
// window if it has not been taken. Tap RAM contents are never cleared: a record
// start resets the write pointer and the index, and taps are only used once the
// index has passed twice the lag. Configuration words are taken every cycle.
module second_difference_peak_detector #(
   parameter int MAX_LAG = sdpd_pkg::MAX_LAG_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample in: tdata = sample[12:0], zero fill; tuser = record_start
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   input  logic                            req_tuser,
   // result out: tdata = peak[11:0], window_start[27:12], zero fill
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sdpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sdpd_pkg::CSR_DATA_W-1:0] csr_data
);
   import sdpd_pkg::*;

   localparam int TAP_DEPTH = 2 * MAX_LAG;
   localparam int PTR_W     = $clog2(TAP_DEPTH);
   localparam int LW        = (LAG_W > PTR_W + 1) ? LAG_W : PTR_W + 1;
   localparam int AW        = LW + 2;

   // configuration registers
   logic [BASE_W-1:0] baseline_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [LAG_W-1:0]  lag_ff;
   logic [ADJ_W-1:0]  adjust_ff;
   logic [WLEN_W-1:0] window_len_ff;
   logic [HOLD_W-1:0] holdoff_ff;

   // control state
   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [WLEN_W-1:0] fill_ff, fill_in;
   logic [PEAK_W-1:0] peak_ff, peak_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SAMPLE_W-1:0]     s_ff, s_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    sat_ff, sat_in;
   logic [31:0]             rsp_data_ff, rsp_data_in;

   // shared unit and tap ram hookup
   logic                     mul_en;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic                     ram_we;
   logic [PTR_W-1:0]         ram_raddr;
   logic [SAMPLE_W-1:0]      ram_rd;

   // derived values
   logic [LW-1:0]           lag_eff;
   logic [LW:0]             back_far;
   logic [AW-1:0]           mid_sum, far_sum, mid_wrap, far_wrap;
   logic [PTR_W-1:0]        mid_addr, far_addr;
   logic                    lag_zero;
   logic [SAMPLE_W-1:0]     tap_val;
   logic signed [Y_W-1:0]   y_cur;
   logic signed [ACC_W-1:0] y_ext;
   logic [ACC_W-1:0]        mag;
   logic                    early;
   logic [WLEN_W-1:0]       wl_eff, fill_inc;
   logic                    win_end;
   logic [IDX_W-1:0]        win_start;
   logic [PEAK_W-1:0]       v_cur, peak_upd, peak_out;
   logic                    out_free;

   sdpd_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   sdpd_tap_ram #(
      .DEPTH (TAP_DEPTH)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ff),
      .wr_data (s_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff   <= BASE_RST;
         gain_ff       <= GAIN_RST;
         lag_ff        <= LAG_RST;
         adjust_ff     <= ADJ_RST;
         window_len_ff <= WLEN_RST;
         holdoff_ff    <= HOLD_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASELINE:   baseline_ff   <= csr_data[BASE_W-1:0];
            CSR_GAIN:       gain_ff       <= csr_data[GAIN_W-1:0];
            CSR_LAG:        lag_ff        <= csr_data[LAG_W-1:0];
            CSR_ADJUST:     adjust_ff     <= csr_data[ADJ_W-1:0];
            CSR_WINDOW_LEN: window_len_ff <= csr_data[WLEN_W-1:0];
            CSR_HOLDOFF:    holdoff_ff    <= csr_data[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // tap addresses, lag saturated to MAX_LAG, half the line length
   always_comb begin
      lag_eff  = (LW'(lag_ff) > LW'(MAX_LAG)) ? LW'(MAX_LAG) : LW'(lag_ff);
      back_far = {lag_eff, 1'b0};
      mid_sum  = AW'(wr_ff) + AW'(TAP_DEPTH) - AW'(lag_eff);
      far_sum  = AW'(wr_ff) + AW'(TAP_DEPTH) - AW'(back_far);
      mid_wrap = (mid_sum >= AW'(TAP_DEPTH)) ? mid_sum - AW'(TAP_DEPTH) : mid_sum;
      far_wrap = (far_sum >= AW'(TAP_DEPTH)) ? far_sum - AW'(TAP_DEPTH) : far_sum;
      mid_addr = mid_wrap[PTR_W-1:0];
      far_addr = far_wrap[PTR_W-1:0];
      lag_zero = (lag_eff == '0);
      tap_val  = lag_zero ? s_ff : ram_rd;
   end

   // scaled tap, magnitude and window bookkeeping
   always_comb begin
      y_cur     = scale_trunc(mul_p);
      y_ext     = {{(ACC_W - Y_W){y_cur[Y_W-1]}}, y_cur};
      mag       = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      early     = (index_ff < IDX_W'(back_far));
      wl_eff    = (window_len_ff == '0) ? WLEN_W'(1) : window_len_ff;
      fill_inc  = fill_ff + WLEN_W'(1);
      win_end   = (fill_inc >= wl_eff);
      win_start = index_ff - IDX_W'(fill_ff);
      v_cur     = sat_ff ? PEAK_LIMIT : mul_p[RECIP_SHIFT+PEAK_W-1:RECIP_SHIFT];
      if (early) begin
         peak_upd = '0;
      end else begin
         peak_upd = (v_cur > peak_ff) ? v_cur : peak_ff;
      end
      peak_out  = (win_start < holdoff_ff) ? '0 : peak_upd;
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ff        <= '0;
         index_ff     <= '0;
         fill_ff      <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         index_ff     <= index_in;
         fill_ff      <= fill_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer: next state, multiplier operands, ram control
   always_comb begin
      state_in     = state_ff;
      wr_in        = wr_ff;
      index_in     = index_ff;
      fill_in      = fill_ff;
      peak_in      = peak_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      mul_en       = 1'b1;
      mul_a        = '0;
      mul_b        = '0;
      ram_we       = 1'b0;
      ram_raddr    = mid_addr;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               s_in = req_tdata[SAMPLE_W-1:0];
               // record start drops the partial window and restarts the line
               if (req_tuser) begin
                  wr_in    = '0;
                  index_in = '0;
                  fill_in  = '0;
                  peak_in  = '0;
               end
               state_in = ST_RD_MID;
            end
         end
         ST_RD_MID: begin
            ram_raddr = mid_addr;
            mul_a     = base_diff(s_ff, baseline_ff);
            mul_b     = $signed(MUL_W'(gain_ff));
            state_in  = ST_RD_FAR;
         end
         ST_RD_FAR: begin
            ram_raddr = far_addr;
            mul_a     = base_diff(tap_val, baseline_ff);
            mul_b     = $signed(MUL_W'(gain_ff));
            acc_in    = y_ext;
            state_in  = ST_WR;
         end
         ST_WR: begin
            // far tap was read last cycle, the slot is free to overwrite
            ram_we   = 1'b1;
            wr_in    = (wr_ff == PTR_W'(TAP_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
            mul_a    = base_diff(tap_val, baseline_ff);
            mul_b    = $signed(MUL_W'(gain_ff));
            acc_in   = acc_ff - (y_ext <<< 1);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + y_ext;
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            mul_a    = $signed(MUL_W'(mag));
            mul_b    = $signed(MUL_W'(adjust_ff));
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // quotient by 100 is exact through the reciprocal below the clamp
            sat_in   = (mul_p >= PROD_W'(SAT_THRESH));
            mul_a    = $signed(MUL_W'(mul_p[RECIP_W-1:0]));
            mul_b    = $signed(RECIP_100);
            state_in = ST_UPD;
         end
         ST_UPD: begin
            mul_en = 1'b0;
            if (!win_end || out_free) begin
               index_in = index_ff + IDX_W'(1);
               if (win_end) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {4'b0, win_start, peak_out};
                  peak_in      = '0;
                  fill_in      = '0;
               end else begin
                  peak_in = peak_upd;
                  fill_in = fill_inc;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/sdpd_checker.sv */
// sdpd_checker: port-level checks on the peak detector, bound to the top level.
// Depends on second_difference_peak_detector and sdpd_pkg for widths.
module sdpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import sdpd_pkg::*;

   // a sample word keeps the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after a sample was taken");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result word changed or dropped while stalled");

   // a new result only appears out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result word appeared without a sample in work");

   // peak stays inside the clamp
   a_peak_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[PEAK_W-1:0] <= PEAK_LIMIT))
      else $error("peak above clamp limit");

endmodule

bind second_difference_peak_detector sdpd_checker u_sdpd_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for the second-difference peak detector.
// Depends on sdpd_pkg and the rtl top; a behavioral predictor checks every rsp word.
module tb_top;
   import sdpd_pkg::*;

   localparam int TAP_DEPTH     = 2 * MAX_LAG_DEF;
   localparam int TAP_AW        = $clog2(TAP_DEPTH);
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [PEAK_W-1:0] peak;
      logic [IDX_W-1:0]  window_start;
   } window_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int failures    = 0;
   int cycle_count = 0;
   int rsp_hold    = 0;
   bit idle_on     = 1'b1;

   // register shadow, reset values
   int cf_baseline = 2047;
   int cf_gain     = 41;
   int cf_lag      = 8;
   int cf_adjust   = 100;
   int cf_wlen     = 64;
   int cf_holdoff  = 0;

   // detector state mirror
   logic [SAMPLE_W-1:0] tap_line [TAP_DEPTH];
   int tap_wr    = 0;
   int rec_index = 0;
   int win_fill  = 0;
   int win_peak  = 0;

   window_word_type expected_windows[$];

   second_difference_peak_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (tap_line[i]) tap_line[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic int draw_gap();
      return idle_on ? int'($urandom_range(0, 7)) : 0;
   endfunction

   // baseline removal and q4.12 gain, truncating toward zero
   function automatic longint scaled(input logic [SAMPLE_W-1:0] raw);
      longint d;
      d = longint'(raw) - cf_baseline;
      return (d * cf_gain) / 4096;
   endfunction

   // advance the mirrored detector by one sample, queue a word at window end
   function automatic void advance_detector(input logic [SAMPLE_W-1:0] s, input bit rec);
      int lag_eff, wl, start;
      logic [SAMPLE_W-1:0] mid, far;
      longint diff, mag, v;
      window_word_type w;
      if (rec) begin
         foreach (tap_line[i]) tap_line[i] = '0;
         tap_wr    = 0;
         rec_index = 0;
         win_fill  = 0;
         win_peak  = 0;
      end
      lag_eff = (cf_lag > MAX_LAG_DEF) ? MAX_LAG_DEF : cf_lag;
      mid = (lag_eff == 0) ? s
            : tap_line[TAP_AW'((tap_wr + TAP_DEPTH - lag_eff) % TAP_DEPTH)];
      far = (lag_eff == 0) ? s
            : tap_line[TAP_AW'((tap_wr + TAP_DEPTH - 2 * lag_eff) % TAP_DEPTH)];
      tap_line[TAP_AW'(tap_wr)] = s;
      tap_wr = (tap_wr + 1) % TAP_DEPTH;

      // early samples clear the peak, later ones feed it
      if (rec_index < 2 * lag_eff) begin
         win_peak = 0;
      end else begin
         diff = scaled(s) + scaled(far) - 2 * scaled(mid);
         mag  = (diff < 0) ? -diff : diff;
         v    = (mag * longint'(cf_adjust)) / 100;
         if (v > win_peak) win_peak = int'(v & 64'hFF_FFFF);
      end

      win_fill++;
      wl = (cf_wlen == 0) ? 1 : cf_wlen;
      if (win_fill >= wl) begin
         start = (rec_index - (win_fill - 1)) & 16'hFFFF;
         w.window_start = start[IDX_W-1:0];
         if (start < cf_holdoff)
            w.peak = '0;
         else if (win_peak > int'(PEAK_LIMIT))
            w.peak = PEAK_LIMIT;
         else
            w.peak = win_peak[PEAK_W-1:0];
         expected_windows.push_back(w);
         win_peak = 0;
         win_fill = 0;
      end
      rec_index = (rec_index + 1) & 16'hFFFF;
   endfunction

   // one sample word; valid stays up for a back-to-back next word
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input bit rec);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, sample};
      req_tuser  <= rec;
      do @(posedge clock); while (!req_tready);
      advance_detector(sample, rec);
   endtask

   // drop valid, wait for all windows, then let the sequencer finish
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_windows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value,
                            input bit last_word);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (last_word) csr_valid <= 1'b0;
      case (idx)
         CSR_BASELINE:   cf_baseline = int'(value[BASE_W-1:0]);
         CSR_GAIN:       cf_gain     = int'(value[GAIN_W-1:0]);
         CSR_LAG:        cf_lag      = int'(value[LAG_W-1:0]);
         CSR_ADJUST:     cf_adjust   = int'(value[ADJ_W-1:0]);
         CSR_WINDOW_LEN: cf_wlen     = int'(value[WLEN_W-1:0]);
         CSR_HOLDOFF:    cf_holdoff  = int'(value[HOLD_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_config(input int base, input int gain, input int lag, input int adj,
                             input int wlen, input int hold);
      wait_drained();
      write_reg(CSR_BASELINE, CSR_DATA_W'(base), 1'b0);
      write_reg(CSR_GAIN, CSR_DATA_W'(gain), 1'b0);
      write_reg(CSR_LAG, CSR_DATA_W'(lag), 1'b0);
      write_reg(CSR_ADJUST, CSR_DATA_W'(adj), 1'b0);
      write_reg(CSR_WINDOW_LEN, CSR_DATA_W'(wlen), 1'b0);
      write_reg(CSR_HOLDOFF, CSR_DATA_W'(hold), 1'b1);
   endtask

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int t;
      case ($urandom_range(0, 3))
         0: t = $urandom_range(0, 8191);
         1: t = $urandom_range(0, 4096);
         2: t = $urandom_range(0, 1) ? 0 : 8191;
         default: begin
            t = cf_baseline + int'($urandom_range(0, 128)) - 64;
            if (t < 0) t = 0;
         end
      endcase
      return t[SAMPLE_W-1:0];
   endfunction

   // result side: random stalls, optional long hold, compare each word
   initial begin : result_check
      int stall;
      window_word_type want;
      logic [PEAK_W-1:0] got_peak;
      logic [IDX_W-1:0] got_start;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = (rsp_hold > 0) ? rsp_hold : draw_gap();
         rsp_hold = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got_peak  = rsp_tdata[PEAK_W-1:0];
         got_start = rsp_tdata[PEAK_W+IDX_W-1:PEAK_W];
         if (expected_windows.size() == 0) begin
            $error("unexpected window word: peak %0d window_start %0d", got_peak, got_start);
            failures++;
         end else begin
            want = expected_windows.pop_front();
            if (got_peak !== want.peak) begin
               $error("peak mismatch: expected %0d, actual %0d", want.peak, got_peak);
               failures++;
            end
            if (got_start !== want.window_start) begin
               $error("window_start mismatch: expected %0d, actual %0d",
                      want.window_start, got_start);
               failures++;
            end
         end
      end
   end

   // full-scale samples against extreme register values
   task automatic test_extremes();
      set_config(0, 65535, 1, 1000, 1, 0);
      send_sample(13'd0, 1'b1);
      send_sample(13'd8191, 1'b0);
      send_sample(13'd0, 1'b0);
      send_sample(13'd8191, 1'b0);
      send_sample(13'd4096, 1'b0);
      set_config(4095, 0, 1, 0, 2, 0);
      send_sample(13'd8191, 1'b1);
      send_sample(13'd0, 1'b0);
      send_sample(13'd8191, 1'b0);
      send_sample(13'd1, 1'b0);
   endtask

   // zero lag, saturated lag, zero window, holdoff, window shrink, record restart
   task automatic test_special_cases();
      set_config(2047, 4096, 0, 100, 1, 0);
      send_sample(13'd8191, 1'b1);
      send_sample(13'd0, 1'b0);
      send_sample(13'd4000, 1'b0);
      set_config(2047, 4096, 127, 100, 0, 0);
      send_sample(13'd100, 1'b0);
      send_sample(13'd8000, 1'b0);
      send_sample(13'd5, 1'b0);
      set_config(1000, 4096, 1, 1000, 2, 65535);
      send_sample(13'd0, 1'b1);
      send_sample(13'd8191, 1'b0);
      send_sample(13'd0, 1'b0);
      send_sample(13'd8191, 1'b0);
      // long window, then shrink it below the current fill
      set_config(2047, 4096, 1, 100, 65535, 0);
      send_sample(13'd3000, 1'b1);
      send_sample(13'd5000, 1'b0);
      send_sample(13'd1000, 1'b0);
      send_sample(13'd6000, 1'b0);
      wait_drained();
      write_reg(CSR_WINDOW_LEN, 16'd3, 1'b1);
      send_sample(13'd2000, 1'b0);
      // a record start drops the partial window
      wait_drained();
      write_reg(CSR_WINDOW_LEN, 16'd4, 1'b1);
      send_sample(13'd7000, 1'b0);
      send_sample(13'd100, 1'b0);
      send_sample(13'd2500, 1'b1);
      send_sample(13'd6500, 1'b0);
      send_sample(13'd200, 1'b0);
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      int i;
      set_config(2047, 4096, 1, 100, 1, 0);
      idle_on  = 1'b0;
      rsp_hold = 300;
      for (i = 0; i < 40; i++) send_sample(rand_sample(), i == 0);
      idle_on = 1'b1;
   endtask

   // random register settings, each followed by a run of samples
   task automatic test_random();
      int phase, sent, n, i;
      bit rec;
      phase = 0;
      sent  = 0;
      while (sent < 470) begin
         set_config(($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 0 : 4095)
                                                : $urandom_range(0, 4095),
                    $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 2048),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, 12),
                    $urandom_range(0, 1000),
                    ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                 : $urandom_range(0, 12),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : 0);
         idle_on = (phase % 3 != 2);
         n = $urandom_range(40, 80);
         for (i = 0; i < n; i++) begin
            rec = (i == 0 && phase > 0 && $urandom_range(0, 3) != 0)
                  || ($urandom_range(0, 49) == 0);
            send_sample(rand_sample(), rec);
         end
         sent += n;
         phase++;
      end
      idle_on = 1'b1;
   endtask

   initial begin : run_tests
      wait (!reset);
      @(posedge clock);
      test_extremes();
      test_special_cases();
      test_backpressure();
      test_random();
      wait_drained();
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
rtl/sdpd_pkg.sv
rtl/sdpd_tap_ram.sv
rtl/sdpd_mul.sv
rtl/second_difference_peak_detector.sv
rtl/sdpd_checker.sv
bench/tb_top.sv
